>>> rtl/core/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, codes and color tables of the particle state update block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psu_pkg;

	// Particle kinds
	localparam logic [2:0] KIND_STATIC   = 3'd0;
	localparam logic [2:0] KIND_GRAV     = 3'd1;
	localparam logic [2:0] KIND_SLOWGRAV = 3'd2;
	localparam logic [2:0] KIND_FIRE     = 3'd3;
	localparam logic [2:0] KIND_EXPLODE  = 3'd4;
	localparam logic [2:0] KIND_EXPLODE2 = 3'd5;
	localparam logic [2:0] KIND_BLOB     = 3'd6;
	localparam logic [2:0] KIND_BLOB2    = 3'd7;

	// Configuration register indexes
	localparam logic REG_FRAME_TIME   = 1'b0;
	localparam logic REG_CURRENT_TIME = 1'b1;

	// Frame time is unsigned Q0.16
	localparam int FT_W = 16;

	// Shifts applied to vel * frame_time (position/drag step, damping step)
	localparam int POS_SHIFT  = 16;
	localparam int DAMP_SHIFT = 14;

	// Gravity per second times frame time: 800 * 0.05
	localparam logic [5:0] GRAV_FACTOR = 6'd40;

	// Ramp speeds per kind, Q4.12 after a shift of four
	localparam logic [3:0] STEP_FIRE     = 4'd5;
	localparam logic [3:0] STEP_EXPLODE  = 4'd10;
	localparam logic [3:0] STEP_EXPLODE2 = 4'd15;

	// Ramp end points: 6.0 for fire, 8.0 for the explode kinds
	localparam logic [15:0] RAMP_END_FIRE    = 16'h6000;
	localparam logic [15:0] RAMP_END_EXPLODE = 16'h8000;

	// Velocity term codes
	localparam logic [1:0] VOP_NONE     = 2'd0;
	localparam logic [1:0] VOP_ADD_DAMP = 2'd1;
	localparam logic [1:0] VOP_SUB_DAMP = 2'd2;
	localparam logic [1:0] VOP_SUB_DRAG = 2'd3;

	// Gravity term codes
	localparam logic [1:0] GOP_NONE = 2'd0;
	localparam logic [1:0] GOP_ADD  = 2'd1;
	localparam logic [1:0] GOP_SUB  = 2'd2;

	// Per-axis control handed to a lane
	typedef struct packed {
		logic       alive;
		logic [1:0] vel_op;
		logic [1:0] grav_op;
	} lane_ctl_t;

	function automatic logic [7:0] fire_color(input logic [2:0] idx);
		case (idx)
			3'd0:    fire_color = 8'h6d;
			3'd1:    fire_color = 8'h6b;
			3'd2:    fire_color = 8'h06;
			3'd3:    fire_color = 8'h05;
			3'd4:    fire_color = 8'h04;
			3'd5:    fire_color = 8'h03;
			default: fire_color = 8'h03;
		endcase
	endfunction

	function automatic logic [7:0] explode_color(input logic [2:0] idx);
		case (idx)
			3'd0:    explode_color = 8'h6f;
			3'd1:    explode_color = 8'h6d;
			3'd2:    explode_color = 8'h6b;
			3'd3:    explode_color = 8'h69;
			3'd4:    explode_color = 8'h67;
			3'd5:    explode_color = 8'h65;
			3'd6:    explode_color = 8'h63;
			3'd7:    explode_color = 8'h61;
			default: explode_color = 8'h61;
		endcase
	endfunction

	function automatic logic [7:0] explode2_color(input logic [2:0] idx);
		case (idx)
			3'd0:    explode2_color = 8'h6f;
			3'd1:    explode2_color = 8'h6e;
			3'd2:    explode2_color = 8'h6d;
			3'd3:    explode2_color = 8'h6c;
			3'd4:    explode2_color = 8'h6b;
			3'd5:    explode2_color = 8'h6a;
			3'd6:    explode2_color = 8'h68;
			3'd7:    explode2_color = 8'h66;
			default: explode2_color = 8'h66;
		endcase
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/psu_lane.sv
// ----------------------------------------------------------------------------
// psu_lane
// One axis of the update: saturating position step and velocity change
// (damping, drag and gravity terms) from a registered vel * frame_time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psu_lane #(
	parameter int VALUE_WIDTH = 32,
	parameter int GRAV_W      = 22
) (
	input  logic signed [VALUE_WIDTH-1:0]              pos,
	input  logic signed [VALUE_WIDTH-1:0]              vel,
	input  logic signed [VALUE_WIDTH+psu_pkg::FT_W:0] prod,
	input  logic        [GRAV_W-1:0]                   grav,
	input  psu_pkg::lane_ctl_t                         ctl,
	output logic signed [VALUE_WIDTH-1:0]              pos_new,
	output logic signed [VALUE_WIDTH-1:0]              vel_new
);

	// Sum width with headroom for four times the velocity and the gravity term
	localparam int SW = ((VALUE_WIDTH > GRAV_W) ? VALUE_WIDTH : GRAV_W) + 4;

	function automatic logic signed [VALUE_WIDTH-1:0] sat(input logic signed [SW-1:0] s);
		logic [SW-VALUE_WIDTH:0] hi_bits;
		hi_bits = s[SW-1:VALUE_WIDTH-1];
		if ((&hi_bits) || !(|hi_bits))
			sat = s[VALUE_WIDTH-1:0];
		else if (s[SW-1])
			sat = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
		else
			sat = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	endfunction

	logic signed [SW-1:0]          step_pos;
	logic signed [SW-1:0]          step_damp;
	logic signed [SW-1:0]          pos_e;
	logic signed [SW-1:0]          vel_e;
	logic signed [SW-1:0]          grav_e;
	logic signed [SW-1:0]          vel_sum;
	logic signed [VALUE_WIDTH-1:0] vel_a;
	logic signed [SW-1:0]          vel_a_e;
	logic signed [SW-1:0]          grav_sum;

	// Floor shifts of the exact product
	assign step_pos  = SW'(prod >>> psu_pkg::POS_SHIFT);
	assign step_damp = SW'(prod >>> psu_pkg::DAMP_SHIFT);
	assign pos_e     = SW'(pos);
	assign vel_e     = SW'(vel);
	assign grav_e    = SW'(signed'({1'b0, grav}));

	// Advance position with the incoming velocity
	assign pos_new = ctl.alive ? sat(pos_e + step_pos) : pos;

	// Apply damping or drag, then gravity, saturating after each
	always_comb begin
		case (ctl.vel_op)
			psu_pkg::VOP_NONE:     vel_sum = vel_e;
			psu_pkg::VOP_ADD_DAMP: vel_sum = vel_e + step_damp;
			psu_pkg::VOP_SUB_DAMP: vel_sum = vel_e - step_damp;
			psu_pkg::VOP_SUB_DRAG: vel_sum = vel_e - step_pos;
			default:               vel_sum = vel_e;
		endcase
		vel_a   = sat(vel_sum);
		vel_a_e = SW'(vel_a);
		case (ctl.grav_op)
			psu_pkg::GOP_NONE: grav_sum = vel_a_e;
			psu_pkg::GOP_ADD:  grav_sum = vel_a_e + grav_e;
			psu_pkg::GOP_SUB:  grav_sum = vel_a_e - grav_e;
			default:           grav_sum = vel_a_e;
		endcase
		vel_new = ctl.alive ? sat(grav_sum) : vel;
	end

endmodule

`default_nettype wire

>>> rtl/core/particle_state_update.sv
// ----------------------------------------------------------------------------
// particle_state_update
// One Euler step per particle: expiry check, saturating position and
// velocity update per kind, and color ramp stepping for fire and explosions.
//
// Takes one particle word per cycle unless held by backpressure, and returns
// exactly one word for it. The word is accepted into an input register.
// The next register holds the three vel * frame_time products (one
// VALUE_WIDTH x 17 multiplier per axis), together with the expiry compare and
// the ramp sum. The output register is where the saturating sums, colors and
// death mark are formed. All stages hold under backpressure, so a new word is
// taken whenever the output register is free or being read. Write frame_time
// and current_time only while no particle is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module particle_state_update #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 12
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	// configuration
	input  logic                                          cfg_we,
	input  logic                                          cfg_index,
	input  logic [31:0]                                   cfg_data,
	// particle in
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	// ramp_in, color_in, pos_x_in, pos_y_in, pos_z_in, vel_x_in, vel_y_in,
	// vel_z_in, death_time_in, zero fill
	input  logic [((24 + 7 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	// particle_kind
	input  logic [2:0]                                    s_tuser,
	// particle out
	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	// ramp_out, color_out, pos_x_out, pos_y_out, pos_z_out, vel_x_out,
	// vel_y_out, vel_z_out, death_time_out, zero fill
	output logic [((24 + 7 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
	// alive
	output logic                                          m_tuser
);

	localparam int VW      = VALUE_WIDTH;
	localparam int TDATA_W = ((24 + 7 * VW + 7) / 8) * 8;
	localparam int PAD_W   = TDATA_W - (24 + 7 * VW);
	localparam int PW      = VW + psu_pkg::FT_W + 1;
	localparam int GSHL    = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
	localparam int GSHR    = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
	localparam int GRAV_W  = 22 + GSHL;
	localparam int POS0    = 24;
	localparam int VEL0    = 24 + 3 * VW;
	localparam int DEATH0  = 24 + 6 * VW;

	// -1.0 in Q.FRAC_BITS
	localparam logic [VW-1:0] DEAD_MARK = {VW{1'b1}} << FRAC_BITS;

	// Configuration registers
	logic [15:0] frame_time_q;
	logic [31:0] current_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_time_q   <= '0;
			current_time_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				psu_pkg::REG_FRAME_TIME:   frame_time_q   <= cfg_data[15:0];
				psu_pkg::REG_CURRENT_TIME: current_time_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Gravity step, a constant for the frame
	logic [21:0]       grav_ft;
	logic [GRAV_W-1:0] grav;

	assign grav_ft = 22'(frame_time_q) * 22'(psu_pkg::GRAV_FACTOR);
	assign grav    = (GRAV_W'(grav_ft) << GSHL) >> GSHR;

	// Handshake between stages
	logic v_s1, v_s2, m_tvalid_q;
	logic adv_out, load_s2;

	assign adv_out  = v_s2 && (!m_tvalid_q || m_tready);
	assign load_s2  = v_s1 && (!v_s2 || adv_out);
	assign s_tready = !v_s1 || load_s2;
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_tready)
				v_s1 <= s_tvalid;
			if (!v_s2 || adv_out)
				v_s2 <= v_s1;
			if (!m_tvalid_q || m_tready)
				m_tvalid_q <= v_s2;
		end
	end

	// Stage 1: input register
	logic [2:0]           kind_s1;
	logic [15:0]          ramp_s1;
	logic [7:0]           color_s1;
	logic signed [VW-1:0] pos_s1 [3];
	logic signed [VW-1:0] vel_s1 [3];
	logic signed [VW-1:0] death_s1;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1  <= s_tuser;
			ramp_s1  <= s_tdata[15:0];
			color_s1 <= s_tdata[23:16];
			for (int i = 0; i < 3; i++) begin
				pos_s1[i] <= s_tdata[POS0 + i * VW +: VW];
				vel_s1[i] <= s_tdata[VEL0 + i * VW +: VW];
			end
			death_s1 <= s_tdata[DEATH0 +: VW];
		end
	end

	// Expiry check and ramp sum
	logic signed [VW-1:0] now_v;
	logic                 alive_c;
	logic                 ramp_kind_c;
	logic [19:0]          ramp_ftk;
	logic [16:0]          ramp_sum;
	logic [15:0]          ramp_c;

	always_comb begin
		now_v       = signed'(VW'(current_time_q));
		alive_c     = !(death_s1 < now_v);
		ramp_kind_c = 1'b1;
		case (kind_s1)
			psu_pkg::KIND_FIRE:     ramp_ftk = 20'(frame_time_q) * 20'(psu_pkg::STEP_FIRE);
			psu_pkg::KIND_EXPLODE:  ramp_ftk = 20'(frame_time_q) * 20'(psu_pkg::STEP_EXPLODE);
			psu_pkg::KIND_EXPLODE2: ramp_ftk = 20'(frame_time_q) * 20'(psu_pkg::STEP_EXPLODE2);
			default: begin
				ramp_ftk    = '0;
				ramp_kind_c = 1'b0;
			end
		endcase
		ramp_sum = {1'b0, ramp_s1} + {1'b0, ramp_ftk[19:4]};
		if (!alive_c || !ramp_kind_c)
			ramp_c = ramp_s1;
		else if (ramp_sum[16])
			ramp_c = 16'hffff;
		else
			ramp_c = ramp_sum[15:0];
	end

	// Stage 2: products and pass-through
	logic [2:0]           kind_s2;
	logic                 alive_s2;
	logic                 ramp_kind_s2;
	logic [15:0]          ramp_s2;
	logic [7:0]           color_s2;
	logic signed [VW-1:0] pos_s2 [3];
	logic signed [VW-1:0] vel_s2 [3];
	logic signed [PW-1:0] prod_s2 [3];
	logic signed [VW-1:0] death_s2;

	always_ff @(posedge clk) begin
		if (load_s2) begin
			kind_s2      <= kind_s1;
			alive_s2     <= alive_c;
			ramp_kind_s2 <= ramp_kind_c && alive_c;
			ramp_s2      <= ramp_c;
			color_s2     <= color_s1;
			for (int i = 0; i < 3; i++) begin
				pos_s2[i]  <= pos_s1[i];
				vel_s2[i]  <= vel_s1[i];
				prod_s2[i] <= PW'(vel_s1[i]) * PW'(signed'({1'b0, frame_time_q}));
			end
			death_s2 <= death_s1;
		end
	end

	// Lane control per kind
	psu_pkg::lane_ctl_t lane_ctl [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lane_ctl[i].alive   = alive_s2;
			lane_ctl[i].vel_op  = psu_pkg::VOP_NONE;
			lane_ctl[i].grav_op = psu_pkg::GOP_NONE;
		end
		case (kind_s2)
			psu_pkg::KIND_GRAV, psu_pkg::KIND_SLOWGRAV: begin
				lane_ctl[2].grav_op = psu_pkg::GOP_SUB;
			end
			psu_pkg::KIND_FIRE: begin
				lane_ctl[2].grav_op = psu_pkg::GOP_ADD;
			end
			psu_pkg::KIND_EXPLODE, psu_pkg::KIND_BLOB: begin
				for (int i = 0; i < 3; i++)
					lane_ctl[i].vel_op = psu_pkg::VOP_ADD_DAMP;
				lane_ctl[2].grav_op = psu_pkg::GOP_SUB;
			end
			psu_pkg::KIND_EXPLODE2: begin
				for (int i = 0; i < 3; i++)
					lane_ctl[i].vel_op = psu_pkg::VOP_SUB_DRAG;
				lane_ctl[2].grav_op = psu_pkg::GOP_SUB;
			end
			psu_pkg::KIND_BLOB2: begin
				lane_ctl[0].vel_op  = psu_pkg::VOP_SUB_DAMP;
				lane_ctl[1].vel_op  = psu_pkg::VOP_SUB_DAMP;
				lane_ctl[2].grav_op = psu_pkg::GOP_SUB;
			end
			default: ;
		endcase
	end

	// Per-axis sums
	logic signed [VW-1:0] pos_new [3];
	logic signed [VW-1:0] vel_new [3];

	for (genvar g = 0; g < 3; g++) begin : g_lane
		psu_lane #(
			.VALUE_WIDTH (VW),
			.GRAV_W      (GRAV_W)
		) u_lane (
			.pos     (pos_s2[g]),
			.vel     (vel_s2[g]),
			.prod    (prod_s2[g]),
			.grav    (grav),
			.ctl     (lane_ctl[g]),
			.pos_new (pos_new[g]),
			.vel_new (vel_new[g])
		);
	end

	// Ramp end check and recolor
	logic            ran_out;
	logic [7:0]      color_c;
	logic [VW-1:0]   death_c;

	always_comb begin
		case (kind_s2)
			psu_pkg::KIND_FIRE: begin
				ran_out = ramp_s2 >= psu_pkg::RAMP_END_FIRE;
				color_c = psu_pkg::fire_color(ramp_s2[14:12]);
			end
			psu_pkg::KIND_EXPLODE: begin
				ran_out = ramp_s2 >= psu_pkg::RAMP_END_EXPLODE;
				color_c = psu_pkg::explode_color(ramp_s2[14:12]);
			end
			psu_pkg::KIND_EXPLODE2: begin
				ran_out = ramp_s2 >= psu_pkg::RAMP_END_EXPLODE;
				color_c = psu_pkg::explode2_color(ramp_s2[14:12]);
			end
			default: begin
				ran_out = 1'b0;
				color_c = color_s2;
			end
		endcase
		death_c = death_s2;
		if (ramp_kind_s2) begin
			if (ran_out)
				death_c = DEAD_MARK;
		end
		if (!ramp_kind_s2 || ran_out)
			color_c = color_s2;
	end

	// Output register
	logic [TDATA_W-1:0] m_tdata_q;
	logic               m_tuser_q;

	always_ff @(posedge clk) begin
		if (adv_out) begin
			m_tuser_q            <= alive_s2;
			m_tdata_q[15:0]      <= ramp_s2;
			m_tdata_q[23:16]     <= color_c;
			for (int i = 0; i < 3; i++) begin
				m_tdata_q[POS0 + i * VW +: VW] <= pos_new[i];
				m_tdata_q[VEL0 + i * VW +: VW] <= vel_new[i];
			end
			m_tdata_q[DEATH0 +: VW] <= death_c;
			if (PAD_W > 0)
				m_tdata_q[TDATA_W-1 -: ((PAD_W > 0) ? PAD_W : 1)] <= '0;
		end
	end

	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule

`default_nettype wire
